/* hdl/wfdm_pkg.sv */
// Shared types, constants and the phase helper function of the window frame difference motion unit.
package wfdm_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SUM_W     = 21;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned CENTER_W  = 10;
  localparam int unsigned HALF_W    = 6;
  localparam int unsigned PHASE_W   = 6;
  localparam int unsigned FWIDTH_W  = 11;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 21;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_X_CENTER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CENTER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FWIDTH    = 3'd5;

  localparam logic [CENTER_W-1:0] RST_X_CENTER  = 10'd43;
  localparam logic [CENTER_W-1:0] RST_Y_CENTER  = 10'd43;
  localparam logic [HALF_W-1:0]   RST_HALF_SIZE = 6'd10;
  localparam logic [PHASE_W-1:0]  RST_STRIDE    = 6'd5;
  localparam logic [SUM_W-1:0]    RST_THRESHOLD = 21'd100;
  localparam logic [FWIDTH_W-1:0] RST_FWIDTH    = 11'd96;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
    logic             clear_peak;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] frame_sum;
    logic             alert;
    logic [SUM_W-1:0] peak_sum;
  } out_item_t;

  typedef struct packed {
    logic [CENTER_W-1:0] window_x_center;
    logic [CENTER_W-1:0] window_y_center;
    logic [HALF_W-1:0]   half_size;
    logic [PHASE_W-1:0]  stride;
    logic [SUM_W-1:0]    alert_threshold;
    logic [FWIDTH_W-1:0] frame_width;
  } cfg_t;

  typedef struct packed {
    logic sample;
    logic last;
    logic clr;
  } op_ctrl_t;

  function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] phase,
                                                    input logic [PHASE_W-1:0] step);
    logic [PHASE_W:0] n;
    n = {1'b0, phase} + 1'b1;
    return (n >= {1'b0, step}) ? '0 : n[PHASE_W-1:0];
  endfunction

endpackage

/* hdl/wfdm_fifo.sv */
// Small register queue used between the front and back parts and for results.
module wfdm_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] store_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]    count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (PTR_W+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_W+1)'(DEPTH))
    else $error("Queue holds more entries than its depth.");

endmodule

/* hdl/wfdm_front.sv */
// Front part: pixel position tracking, window test and sample slot numbering.
module wfdm_front #(
  parameter int unsigned MAX_HALF_SIZE = 40,
  parameter int unsigned STORE_DEPTH   = 6400,
  parameter int unsigned MAX_WIDTH     = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wfdm_pkg::cfg_t                        cfg_i,
  input  logic                                  accept_i,
  input  wfdm_pkg::in_item_t                    item_i,
  output logic                                  op_push_o,
  output wfdm_pkg::op_ctrl_t                    op_ctrl_o,
  output logic [wfdm_pkg::PIX_W-1:0]            op_pixel_o,
  output logic [$clog2(STORE_DEPTH)-1:0]        op_slot_o
);

  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
  localparam int unsigned SLOT_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EXT_W  = (WW > wfdm_pkg::FWIDTH_W) ? WW : wfdm_pkg::FWIDTH_W;
  localparam int unsigned CMP_W  = ((COL_W > wfdm_pkg::CENTER_W) ? COL_W
                                                                 : wfdm_pkg::CENTER_W) + 1;
  localparam int unsigned RCMP_W = wfdm_pkg::CENTER_W + 1;

  logic [COL_W-1:0]             col_q, col_d;
  logic [wfdm_pkg::ROW_W-1:0]   row_q, row_d;
  logic [SLOT_W-1:0]            slot_q, slot_d;
  logic [wfdm_pkg::PHASE_W-1:0] cph_q, cph_d;
  logic [wfdm_pkg::PHASE_W-1:0] rph_q, rph_d;

  logic [wfdm_pkg::PHASE_W-1:0] step;
  logic [wfdm_pkg::HALF_W-1:0]  hs;
  logic [EXT_W-1:0]             width;
  logic                         col_in, row_in, col_end, sample;

  always_comb begin
    step = (cfg_i.stride == '0) ? wfdm_pkg::PHASE_W'(1) : cfg_i.stride;
    hs = ({1'b0, cfg_i.half_size} > (wfdm_pkg::HALF_W+1)'(MAX_HALF_SIZE))
         ? wfdm_pkg::HALF_W'(MAX_HALF_SIZE) : cfg_i.half_size;
    if (cfg_i.frame_width == '0) begin
      width = EXT_W'(1);
    end else if (EXT_W'(cfg_i.frame_width) > EXT_W'(MAX_WIDTH)) begin
      width = EXT_W'(MAX_WIDTH);
    end else begin
      width = EXT_W'(cfg_i.frame_width);
    end
    col_in = (CMP_W'(col_q) + CMP_W'(hs) >= CMP_W'(cfg_i.window_x_center)) &&
             (CMP_W'(col_q) < CMP_W'(cfg_i.window_x_center) + CMP_W'(hs));
    row_in = (RCMP_W'(row_q) + RCMP_W'(hs) >= RCMP_W'(cfg_i.window_y_center)) &&
             (RCMP_W'(row_q) < RCMP_W'(cfg_i.window_y_center) + RCMP_W'(hs));
    col_end = (EXT_W'(col_q) + EXT_W'(1) >= width);
    sample = col_in && row_in && (cph_q == '0) && (rph_q == '0) &&
             (slot_q < SLOT_W'(STORE_DEPTH));
  end

  always_comb begin
    col_d  = col_q + 1'b1;
    row_d  = row_q;
    slot_d = sample ? slot_q + 1'b1 : slot_q;
    cph_d  = col_in ? wfdm_pkg::next_phase(cph_q, step) : cph_q;
    rph_d  = rph_q;
    if (col_end) begin
      col_d = '0;
      cph_d = '0;
      row_d = row_q + 1'b1;
      if (row_in) begin
        rph_d = wfdm_pkg::next_phase(rph_q, step);
      end
    end
    if (item_i.frame_end) begin
      col_d  = '0;
      row_d  = '0;
      slot_d = '0;
      cph_d  = '0;
      rph_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
      cph_q  <= '0;
      rph_q  <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
      cph_q  <= cph_d;
      rph_q  <= rph_d;
    end
  end

  assign op_ctrl_o.sample = sample;
  assign op_ctrl_o.last   = item_i.frame_end;
  assign op_ctrl_o.clr    = item_i.clear_peak;
  assign op_pixel_o       = item_i.pixel;
  assign op_slot_o        = slot_q[ADDR_W-1:0];
  assign op_push_o        = accept_i && (sample || item_i.frame_end || item_i.clear_peak);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(STORE_DEPTH))
    else $error("Sample slot ran past the reference store.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.frame_end) |=> (slot_q == '0 && col_q == '0 && row_q == '0))
    else $error("Frame end did not restart the position counters.");

endmodule

/* hdl/wfdm_back.sv */
// Back part: reference store, difference accumulation, peak tracking and results.
module wfdm_back #(
  parameter int unsigned STORE_DEPTH = 6400
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [wfdm_pkg::SUM_W-1:0]          threshold_i,
  input  logic                                op_valid_i,
  input  wfdm_pkg::op_ctrl_t                  op_ctrl_i,
  input  logic [wfdm_pkg::PIX_W-1:0]          op_pixel_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]      op_slot_i,
  output logic                                op_pop_o,
  input  logic                                res_full_i,
  output logic                                res_push_o,
  output wfdm_pkg::out_item_t                 res_o
);

  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
  localparam int unsigned SLOT_W = $clog2(STORE_DEPTH + 1);

  logic [wfdm_pkg::PIX_W-1:0] mem [STORE_DEPTH];

  logic                        b_valid_q;
  wfdm_pkg::op_ctrl_t          b_ctrl_q;
  logic [wfdm_pkg::PIX_W-1:0]  b_pixel_q;
  logic [ADDR_W-1:0]           b_slot_q;
  logic [wfdm_pkg::PIX_W-1:0]  rdata_q;
  logic                        byp_q;
  logic [wfdm_pkg::PIX_W-1:0]  byp_pix_q;
  logic                        known_q;
  logic [SLOT_W-1:0]           fill_q;
  logic [wfdm_pkg::SUM_W-1:0]  run_q;
  logic [wfdm_pkg::SUM_W-1:0]  peak_q;

  logic                        b_fire, b_free, wr_en, hit;
  logic [wfdm_pkg::PIX_W-1:0]  old_pix, diff;
  logic [wfdm_pkg::SUM_W:0]    acc;
  logic [wfdm_pkg::SUM_W-1:0]  sum_now, peak_new;

  assign b_fire   = b_valid_q && !(b_ctrl_q.last && res_full_i);
  assign b_free   = !b_valid_q || b_fire;
  assign op_pop_o = op_valid_i && b_free;
  assign wr_en    = b_fire && b_ctrl_q.sample;
  assign hit      = wr_en && (b_slot_q == op_slot_i);

  always_comb begin
    if (byp_q) begin
      old_pix = byp_pix_q;
    end else if (known_q) begin
      old_pix = rdata_q;
    end else begin
      old_pix = '0;
    end
    diff = (b_pixel_q > old_pix) ? b_pixel_q - old_pix : old_pix - b_pixel_q;
    acc  = {1'b0, run_q} + (wfdm_pkg::SUM_W+1)'(diff);
    if (!b_ctrl_q.sample) begin
      sum_now = run_q;
    end else if (acc[wfdm_pkg::SUM_W]) begin
      sum_now = wfdm_pkg::SUM_MAX;
    end else begin
      sum_now = acc[wfdm_pkg::SUM_W-1:0];
    end
    peak_new = (sum_now > peak_q) ? sum_now : peak_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[b_slot_q] <= b_pixel_q;
    end
    if (op_pop_o) begin
      rdata_q <= mem[op_slot_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      b_pixel_q <= op_pixel_i;
      b_slot_q  <= op_slot_i;
      byp_q     <= hit;
      byp_pix_q <= b_pixel_q;
      known_q   <= (SLOT_W'(op_slot_i) < fill_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_ctrl_q  <= '0;
      fill_q    <= '0;
      run_q     <= '0;
      peak_q    <= '0;
    end else begin
      if (b_free) begin
        b_valid_q <= op_valid_i;
      end
      if (op_pop_o) begin
        b_ctrl_q <= op_ctrl_i;
      end
      if (wr_en && (SLOT_W'(b_slot_q) >= fill_q)) begin
        fill_q <= SLOT_W'(b_slot_q) + 1'b1;
      end
      if (b_fire) begin
        if (b_ctrl_q.last) begin
          run_q <= '0;
        end else begin
          run_q <= sum_now;
        end
        if (b_ctrl_q.clr) begin
          peak_q <= '0;
        end else if (b_ctrl_q.last) begin
          peak_q <= peak_new;
        end
      end
    end
  end

  assign res_push_o      = b_fire && b_ctrl_q.last;
  assign res_o.frame_sum = sum_now;
  assign res_o.alert     = (sum_now >= threshold_i);
  assign res_o.peak_sum  = peak_new;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= SLOT_W'(STORE_DEPTH))
    else $error("Fill count exceeds the reference store depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push_o && res_full_i))
    else $error("Result pushed into a full result queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && b_ctrl_q.last) |=> (run_q == '0))
    else $error("Running sum not cleared after a frame result.");

endmodule

/* hdl/window_frame_difference_motion_unit.sv */
// Top level of the window frame difference motion unit.
// Pixels enter in raster order through a queue-style input: an item transfers
// when push is high and full is low. Results leave through a queue-style
// output: while empty is low the oldest result is on out_item_o, and it
// transfers when pop is high. Only an item that marks the end of a frame
// yields a result. Registers are written through a separate channel (valid,
// ready, cfg_index_i, cfg_data_i); ready is always high.
// One pixel is taken every cycle while full is low. A result passes through the
// operation queue, then the back part's stage, which holds the registered read
// of the reference store, and then the result queue before it is shown.
// After reset all counters, sums and the peak are zero and the reference
// store reads as zero: a fill count marks which entries hold data, so no
// clearing pass is needed and items are taken from the first cycle.
// When the receiver stalls, two results wait in the result queue, then the
// back part halts, the operation queue fills and full rises.
module window_frame_difference_motion_unit #(
  parameter int unsigned MAX_HALF_SIZE = 40,
  parameter int unsigned STORE_DEPTH   = 6400,
  parameter int unsigned MAX_WIDTH     = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  wfdm_pkg::in_item_t                in_item_i,
  output logic                              empty,
  input  logic                              pop,
  output wfdm_pkg::out_item_t               out_item_o,
  input  logic                              valid,
  output logic                              ready,
  input  logic [wfdm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wfdm_pkg::CFG_DAT_W-1:0]    cfg_data_i
);

  localparam int unsigned ADDR_W  = $clog2(STORE_DEPTH);
  localparam int unsigned OP_W    = ADDR_W + wfdm_pkg::PIX_W + $bits(wfdm_pkg::op_ctrl_t);
  localparam int unsigned RES_W   = $bits(wfdm_pkg::out_item_t);
  localparam int unsigned OP_DEPTH  = 4;
  localparam int unsigned RES_DEPTH = 2;

  wfdm_pkg::cfg_t              cfg_q;
  logic                        accept;

  logic                        f_push;
  wfdm_pkg::op_ctrl_t          f_ctrl;
  logic [wfdm_pkg::PIX_W-1:0]  f_pixel;
  logic [ADDR_W-1:0]           f_slot;

  logic [OP_W-1:0]             q_head;
  logic                        q_empty, q_pop;
  wfdm_pkg::op_ctrl_t          q_ctrl;
  logic [wfdm_pkg::PIX_W-1:0]  q_pixel;
  logic [ADDR_W-1:0]           q_slot;

  logic                        res_push, res_full;
  wfdm_pkg::out_item_t         res;
  logic [RES_W-1:0]            res_head;

  assign ready  = 1'b1;
  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_x_center <= wfdm_pkg::RST_X_CENTER;
      cfg_q.window_y_center <= wfdm_pkg::RST_Y_CENTER;
      cfg_q.half_size       <= wfdm_pkg::RST_HALF_SIZE;
      cfg_q.stride          <= wfdm_pkg::RST_STRIDE;
      cfg_q.alert_threshold <= wfdm_pkg::RST_THRESHOLD;
      cfg_q.frame_width     <= wfdm_pkg::RST_FWIDTH;
    end else if (valid && ready) begin
      case (cfg_index_i)
        wfdm_pkg::REG_X_CENTER:  cfg_q.window_x_center <= cfg_data_i[wfdm_pkg::CENTER_W-1:0];
        wfdm_pkg::REG_Y_CENTER:  cfg_q.window_y_center <= cfg_data_i[wfdm_pkg::CENTER_W-1:0];
        wfdm_pkg::REG_HALF_SIZE: cfg_q.half_size       <= cfg_data_i[wfdm_pkg::HALF_W-1:0];
        wfdm_pkg::REG_STRIDE:    cfg_q.stride          <= cfg_data_i[wfdm_pkg::PHASE_W-1:0];
        wfdm_pkg::REG_THRESHOLD: cfg_q.alert_threshold <= cfg_data_i[wfdm_pkg::SUM_W-1:0];
        wfdm_pkg::REG_FWIDTH:    cfg_q.frame_width     <= cfg_data_i[wfdm_pkg::FWIDTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wfdm_front #(
    .MAX_HALF_SIZE (MAX_HALF_SIZE),
    .STORE_DEPTH   (STORE_DEPTH),
    .MAX_WIDTH     (MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .op_push_o  (f_push),
    .op_ctrl_o  (f_ctrl),
    .op_pixel_o (f_pixel),
    .op_slot_o  (f_slot)
  );

  wfdm_fifo #(
    .DATA_W (OP_W),
    .DEPTH  (OP_DEPTH)
  ) u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  ({f_slot, f_pixel, f_ctrl}),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .empty_o (q_empty)
  );

  assign {q_slot, q_pixel, q_ctrl} = q_head;

  wfdm_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (cfg_q.alert_threshold),
    .op_valid_i  (!q_empty),
    .op_ctrl_i   (q_ctrl),
    .op_pixel_i  (q_pixel),
    .op_slot_i   (q_slot),
    .op_pop_o    (q_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  wfdm_fifo #(
    .DATA_W (RES_W),
    .DEPTH  (RES_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign out_item_o = res_head;

endmodule

/* tb/window_frame_difference_motion_unit_test.sv */
// Self-checking testbench for the window frame difference motion unit and its predictor.
`timescale 1ns / 1ps

module window_frame_difference_motion_unit_test;

  localparam int CLAMP_HALF   = 40;
  localparam int STORE_SLOTS  = 6400;
  localparam int WIDTH_CEIL   = 1024;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  logic                           clk_i;
  logic                           rst_ni    = 1'b0;
  logic                           push      = 1'b0;
  logic                           full;
  wfdm_pkg::in_item_t             in_item   = '0;
  logic                           empty;
  logic                           pop       = 1'b0;
  wfdm_pkg::out_item_t            out_item;
  logic                           valid     = 1'b0;
  logic                           ready;
  logic [wfdm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wfdm_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

  wfdm_pkg::cfg_t                shadow_cfg;
  logic [9:0]                    col_cnt;
  logic [wfdm_pkg::ROW_W-1:0]    row_cnt;
  logic [12:0]                   slot_cnt;
  logic [wfdm_pkg::PHASE_W-1:0]  col_ph;
  logic [wfdm_pkg::PHASE_W-1:0]  row_ph;
  logic [wfdm_pkg::SUM_W-1:0]    frame_acc;
  logic [wfdm_pkg::SUM_W-1:0]    peak_hold;
  logic [wfdm_pkg::PIX_W-1:0]    ref_pix [STORE_SLOTS];
  wfdm_pkg::out_item_t           frame_results_due [$];
  wfdm_pkg::out_item_t           due_item;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int error_count  = 0;
  int pixels_sent  = 0;
  int frames_seen  = 0;
  int cycle_count  = 0;

  window_frame_difference_motion_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .valid       (valid),
    .ready       (ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("error at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic logic [wfdm_pkg::PHASE_W-1:0] step_phase(
      logic [wfdm_pkg::PHASE_W-1:0] ph, int step);
    int n;
    n = int'(ph) + 1;
    return (n >= step) ? '0 : n[wfdm_pkg::PHASE_W-1:0];
  endfunction

  function automatic void predict_motion(wfdm_pkg::in_item_t it);
    int step, hs, w, xc, yc, col, row, old_pix, diff, acc;
    bit col_in, row_in;
    wfdm_pkg::out_item_t res;
    step = (shadow_cfg.stride == 0) ? 1 : int'(shadow_cfg.stride);
    hs = (int'(shadow_cfg.half_size) > CLAMP_HALF) ? CLAMP_HALF : int'(shadow_cfg.half_size);
    w = (shadow_cfg.frame_width == 0) ? 1 : int'(shadow_cfg.frame_width);
    if (w > WIDTH_CEIL) w = WIDTH_CEIL;
    xc = int'(shadow_cfg.window_x_center);
    yc = int'(shadow_cfg.window_y_center);
    col = int'(col_cnt);
    row = int'(row_cnt);
    col_in = (col >= xc - hs) && (col < xc + hs);
    row_in = (row >= yc - hs) && (row < yc + hs);
    if (col_in && row_in && col_ph == 0 && row_ph == 0 && int'(slot_cnt) < STORE_SLOTS) begin
      old_pix = int'(ref_pix[slot_cnt]);
      diff = (int'(it.pixel) > old_pix) ? int'(it.pixel) - old_pix : old_pix - int'(it.pixel);
      acc = int'(frame_acc) + diff;
      if (acc > int'(wfdm_pkg::SUM_MAX)) acc = int'(wfdm_pkg::SUM_MAX);
      frame_acc = acc[wfdm_pkg::SUM_W-1:0];
      ref_pix[slot_cnt] = it.pixel;
      slot_cnt = slot_cnt + 1'b1;
    end
    if (col_in) col_ph = step_phase(col_ph, step);
    if (col + 1 >= w) begin
      col_cnt = '0;
      col_ph = '0;
      if (row_in) row_ph = step_phase(row_ph, step);
      row_cnt = row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    if (it.frame_end) begin
      if (frame_acc > peak_hold) peak_hold = frame_acc;
      res.frame_sum = frame_acc;
      res.alert = (frame_acc >= shadow_cfg.alert_threshold);
      res.peak_sum = peak_hold;
      frame_results_due.push_back(res);
      col_cnt = '0;
      row_cnt = '0;
      slot_cnt = '0;
      col_ph = '0;
      row_ph = '0;
      frame_acc = '0;
    end
    if (it.clear_peak) peak_hold = '0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      frames_seen++;
      if (frame_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result, frame_sum %0d", out_item.frame_sum));
      end else begin
        due_item = frame_results_due.pop_front();
        if (out_item.frame_sum !== due_item.frame_sum)
          report_mismatch($sformatf("frame_sum %0d, predicted %0d",
                                    out_item.frame_sum, due_item.frame_sum));
        if (out_item.alert !== due_item.alert)
          report_mismatch($sformatf("alert %b, predicted %b", out_item.alert, due_item.alert));
        if (out_item.peak_sum !== due_item.peak_sum)
          report_mismatch($sformatf("peak_sum %0d, predicted %0d",
                                    out_item.peak_sum, due_item.peak_sum));
      end
    end
    pop <= rst_ni && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic feed_pixel(logic [wfdm_pkg::PIX_W-1:0] pix, logic last, logic clr);
    wfdm_pkg::in_item_t it;
    it = '{pixel: pix, frame_end: last, clear_peak: clr};
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    predict_motion(it);
    pixels_sent++;
  endtask

  // The sender holds off until every predicted result is checked, then lets the pipeline drain.
  task automatic drain_results();
    push <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [wfdm_pkg::CFG_IDX_W-1:0] idx,
                           logic [wfdm_pkg::CFG_DAT_W-1:0] data);
    valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!ready);
    valid <= 1'b0;
    case (idx)
      wfdm_pkg::REG_X_CENTER:  shadow_cfg.window_x_center = data[wfdm_pkg::CENTER_W-1:0];
      wfdm_pkg::REG_Y_CENTER:  shadow_cfg.window_y_center = data[wfdm_pkg::CENTER_W-1:0];
      wfdm_pkg::REG_HALF_SIZE: shadow_cfg.half_size = data[wfdm_pkg::HALF_W-1:0];
      wfdm_pkg::REG_STRIDE:    shadow_cfg.stride = data[wfdm_pkg::PHASE_W-1:0];
      wfdm_pkg::REG_THRESHOLD: shadow_cfg.alert_threshold = data[wfdm_pkg::SUM_W-1:0];
      wfdm_pkg::REG_FWIDTH:    shadow_cfg.frame_width = data[wfdm_pkg::FWIDTH_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_window(int x, int y, int hs, int step, int thresh, int w);
    drain_results();
    write_reg(wfdm_pkg::REG_X_CENTER, wfdm_pkg::CFG_DAT_W'(x));
    write_reg(wfdm_pkg::REG_Y_CENTER, wfdm_pkg::CFG_DAT_W'(y));
    write_reg(wfdm_pkg::REG_HALF_SIZE, wfdm_pkg::CFG_DAT_W'(hs));
    write_reg(wfdm_pkg::REG_STRIDE, wfdm_pkg::CFG_DAT_W'(step));
    write_reg(wfdm_pkg::REG_THRESHOLD, wfdm_pkg::CFG_DAT_W'(thresh));
    write_reg(wfdm_pkg::REG_FWIDTH, wfdm_pkg::CFG_DAT_W'(w));
  endtask

  task automatic test_reset_defaults();
    feed_pixel(8'd200, 1'b0, 1'b0);
    feed_pixel(8'd17, 1'b1, 1'b0);
  endtask

  task automatic test_pixel_extremes();
    set_window(1, 1, 1, 0, 255, 2);
    for (int i = 0; i < 4; i++) feed_pixel((i % 2 == 0) ? 8'd255 : 8'd0, i == 3, 1'b0);
    for (int i = 0; i < 4; i++) feed_pixel((i % 2 == 0) ? 8'd0 : 8'd255, i == 3, 1'b0);
  endtask

  task automatic test_peak_clear();
    feed_pixel(8'd90, 1'b0, 1'b1);
    feed_pixel(8'd10, 1'b1, 1'b0);
    feed_pixel(8'd255, 1'b1, 1'b1);
  endtask

  task automatic test_edge_settings();
    set_window(1, 0, 0, 1, 0, 4);
    feed_pixel(8'd255, 1'b0, 1'b0);
    feed_pixel(8'd1, 1'b1, 1'b0);
    set_window(0, 0, 63, 63, 21'h1FFFFF, 0);
    feed_pixel(8'd128, 1'b0, 1'b0);
    feed_pixel(8'd64, 1'b1, 1'b0);
    set_window(1023, 1023, 5, 2, 50, 2047);
    feed_pixel(8'd77, 1'b0, 1'b0);
    feed_pixel(8'd250, 1'b1, 1'b0);
  endtask

  task automatic test_stride_change();
    set_window(2, 2, 2, 3, 0, 4);
    feed_pixel(8'd40, 1'b0, 1'b0);
    feed_pixel(8'd80, 1'b0, 1'b0);
    drain_results();
    write_reg(wfdm_pkg::REG_STRIDE, wfdm_pkg::CFG_DAT_W'(2));
    feed_pixel(8'd120, 1'b0, 1'b0);
    feed_pixel(8'd160, 1'b1, 1'b0);
  endtask

  task automatic run_random_traffic(int n_items, int tx_pct, int rx_pct);
    int sent_here, len, pix, x, y, hs, step, thresh, w;
    bit clr;
    logic [wfdm_pkg::PIX_W-1:0] prev_frame [$];
    logic [wfdm_pkg::PIX_W-1:0] this_frame [$];
    sent_here = 0;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    while (sent_here < n_items) begin
      if (sent_here == 0 || $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0: w = 0;
          1: w = 2047;
          2: w = $urandom_range(0, 2047);
          default: w = $urandom_range(1, 12);
        endcase
        x = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 14) : $urandom_range(0, 1023);
        y = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 14) : $urandom_range(0, 1023);
        hs = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(0, 63);
        step = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(0, 63);
        case ($urandom_range(0, 5))
          0: thresh = 0;
          1: thresh = 21'h1FFFFF;
          2: thresh = $urandom_range(0, 21'h1FFFFF);
          default: thresh = $urandom_range(0, 1500);
        endcase
        set_window(x, y, hs, step, thresh, w);
      end
      len = $urandom_range(1, 40);
      this_frame.delete();
      for (int i = 0; i < len; i++) begin
        if (i < prev_frame.size() && $urandom_range(0, 1) == 1) begin
          pix = int'(prev_frame[i]) + $urandom_range(0, 6) - 3;
          if (pix < 0) pix = 0;
          if (pix > 255) pix = 255;
        end else begin
          pix = $urandom_range(0, 255);
        end
        clr = ($urandom_range(0, 99) < 8);
        this_frame.push_back(pix[wfdm_pkg::PIX_W-1:0]);
        feed_pixel(pix[wfdm_pkg::PIX_W-1:0], i == len - 1, clr);
      end
      prev_frame = this_frame;
      sent_here += len;
    end
  endtask

  initial begin
    shadow_cfg = '{window_x_center: wfdm_pkg::RST_X_CENTER,
                   window_y_center: wfdm_pkg::RST_Y_CENTER,
                   half_size: wfdm_pkg::RST_HALF_SIZE, stride: wfdm_pkg::RST_STRIDE,
                   alert_threshold: wfdm_pkg::RST_THRESHOLD,
                   frame_width: wfdm_pkg::RST_FWIDTH};
    col_cnt = '0;
    row_cnt = '0;
    slot_cnt = '0;
    col_ph = '0;
    row_ph = '0;
    frame_acc = '0;
    peak_hold = '0;
    foreach (ref_pix[i]) ref_pix[i] = '0;
    tx_idle_pct = 34;
    rx_stall_pct = 61;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_pixel_extremes();
    test_peak_clear();
    test_edge_settings();
    test_stride_change();
    run_random_traffic(175, 34, 61);
    run_random_traffic(175, 61, 34);
    run_random_traffic(175, 0, 0);
    drain_results();

    $display("Sent %0d pixels and checked %0d frame results.", pixels_sent, frames_seen);
    $display("Covered window edge settings, a mid-frame stride change and three idling mixes.");
    if (error_count == 0 && frame_results_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/wfdm_pkg.sv
hdl/wfdm_fifo.sv
hdl/wfdm_front.sv
hdl/wfdm_back.sv
hdl/window_frame_difference_motion_unit.sv
tb/window_frame_difference_motion_unit_test.sv
